// ----- rtl/core/mots_pkg.sv -----
// Package: shared constants and types for the masked one-sample t statistic block.
`timescale 1ns / 1ps
package mots_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned SumW    = 32;
  localparam int unsigned SsqW    = 56;
  localparam int unsigned TW      = 32;
  localparam int unsigned ProdW   = 128;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StMasked   = 2'd1;
  localparam logic [1:0] StDegen    = 2'd2;
  localparam logic [1:0] StTooMany  = 2'd3;

  // Request from the accumulator to the t unit.
  typedef struct packed {
    logic [SumW-1:0] sum_mag;
    logic            sum_neg;
    logic [SsqW-1:0] sumsq;
    logic [8:0]      n;
  } mots_req_t;

endpackage

// ----- rtl/core/masked_one_sample_t_statistic.sv -----
// Top level: per-voxel accumulation and t statistic stream block.
`timescale 1ns / 1ps
// One sample is accepted per clock while the t unit is idle and the output
// register can take a result. On the last transaction the block computes
// t = sum*sqrt((n-1)/(n*sumsq-sum^2)) in a shared bit-serial 64x64
// multiplier: three products and then 32 candidate steps of two products
// each, during which no sample is accepted. A degenerate voxel stops after
// two products. Status 3 (more than MAX_SUBJECTS samples) and status 1
// (masked sample) skip the computation. The result waits in an output
// register; t_value is Q15.16, saturated.
module masked_one_sample_t_statistic
  import mots_pkg::*;
#(
  parameter int unsigned MAX_SUBJECTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,      // use_masks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,    // [23:0] sample, [39:24] mask_value
  input  logic        s_axis_tlast,    // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // [31:0] t_value
  output logic [1:0]  m_axis_tuser     // [1:0] status
);

  localparam logic [8:0] MaxN = 9'(MAX_SUBJECTS);

  logic            use_masks_q;
  logic [8:0]      cnt_q, inc_q;
  logic [SumW-1:0] sum_q;
  logic [SsqW-1:0] ssq_q;
  logic            busy_q, ovalid_q;
  logic [31:0]     ot_q;
  logic [1:0]      ost_q;
  logic            acc;
  logic signed [SampleW-1:0] x;
  logic [SampleW-1:0] ax;
  logic [47:0]     sq;
  logic            incl;
  logic [8:0]      cnt_n, inc_n;
  logic [SumW-1:0] sum_n;
  logic [SsqW-1:0] ssq_n;
  logic            tstart, tdone;
  logic [TW-1:0]   tt;
  logic [1:0]      tst;
  mots_req_t       req;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !busy_q && !(ovalid_q && !m_axis_tready);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign x   = s_axis_tdata[23:0];
  assign ax  = x[SampleW-1] ? SampleW'(-x) : x;
  assign sq  = 48'(ax) * 48'(ax);
  assign incl = !use_masks_q || ($signed(s_axis_tdata[39:24]) > 16'sd0);

  // Next accumulator values for the accepted sample
  always_comb begin
    cnt_n = cnt_q; inc_n = inc_q; sum_n = sum_q; ssq_n = ssq_q;
    if (cnt_q >= MaxN) cnt_n = MaxN + 9'd1;
    else begin
      cnt_n = cnt_q + 9'd1;
      if (incl) begin
        inc_n = inc_q + 9'd1;
        sum_n = sum_q + SumW'(x);
        ssq_n = ssq_q + SsqW'(sq);
      end
    end
  end

  assign req.n       = cnt_n;
  assign req.sum_neg = sum_n[SumW-1];
  assign req.sum_mag = sum_n[SumW-1] ? SumW'(-sum_n) : sum_n;
  assign req.sumsq   = ssq_n;
  assign tstart = acc && s_axis_tlast && !(cnt_n > MaxN) && !(inc_n < cnt_n);

  mots_tunit u_t (
    .clk_i, .rst_ni, .start_i(tstart), .req_i(req), .done_o(tdone), .t_o(tt), .st_o(tst)
  );

  // Control and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_masks_q <= 1'b0; cnt_q <= '0; inc_q <= '0; sum_q <= '0; ssq_q <= '0;
      busy_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) use_masks_q <= cfg_data_i;
      if (m_axis_tready) ovalid_q <= 1'b0;
      if (acc) begin
        if (s_axis_tlast) begin
          cnt_q <= '0; inc_q <= '0; sum_q <= '0; ssq_q <= '0;
          if (tstart) busy_q <= 1'b1;
          else ovalid_q <= 1'b1;
        end else begin
          cnt_q <= cnt_n; inc_q <= inc_n; sum_q <= sum_n; ssq_q <= ssq_n;
        end
      end
      if (tdone) begin busy_q <= 1'b0; ovalid_q <= 1'b1; end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (acc && s_axis_tlast && !tstart) begin
      ot_q  <= '0;
      ost_q <= (cnt_n > MaxN) ? StTooMany : StMasked;
    end
    if (tdone) begin ot_q <= tt; ost_q <= tst; end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = ot_q;
  assign m_axis_tuser  = ost_q;

endmodule

// ----- rtl/core/mots_serial_mul.sv -----
// Shift-add multiplier: one multiplier bit per cycle, 128-bit product.
`timescale 1ns / 1ps
module mots_serial_mul
  import mots_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [63:0]      a_i,
  input  logic [63:0]      b_i,
  output logic             done_o,
  output logic [ProdW-1:0] p_o
);

  logic [ProdW-1:0] acc_q, acc_d, mc_q, mc_d;
  logic [63:0]      mp_q, mp_d;
  logic [6:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  // Add shifted multiplicand when the current multiplier bit is set
  always_comb begin
    acc_d = acc_q; mc_d = mc_q; mp_d = mp_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      acc_d = '0; mc_d = {64'd0, a_i}; mp_d = b_i; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (mp_q[0]) acc_d = acc_q + mc_q;
      mc_d = {mc_q[ProdW-2:0], 1'b0};
      mp_d = {1'b0, mp_q[63:1]};
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; mc_q <= mc_d; mp_q <= mp_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ----- rtl/core/mots_tunit.sv -----
// t computation: n*sumsq, sum^2, rhs and a bit-by-bit quotient search.
`timescale 1ns / 1ps
module mots_tunit
  import mots_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  mots_req_t       req_i,
  output logic            done_o,
  output logic [TW-1:0]   t_o,
  output logic [1:0]      st_o
);

  localparam logic [3:0] S_IDLE = 4'd0, S_NSS = 4'd1, S_S2 = 4'd2, S_CHK = 4'd3,
                         S_RHS = 4'd4, S_CSQ = 4'd5, S_CD = 4'd6, S_DONE = 4'd7;

  logic [3:0]      state_q;
  logic            mstart;
  logic [63:0]     ma, mb;
  logic            mdone;
  logic [ProdW-1:0] mp;
  logic [63:0]     nss_q, s2_q, d_q, csq_q;
  logic [ProdW-1:0] rhs_q;
  logic [TW-1:0]   q_q;
  logic [4:0]      bit_q;
  logic [1:0]      st_q;
  mots_req_t       r_q;
  logic            done_q;
  logic [TW-1:0]   cand;
  logic [32:0]     limit;
  logic            run_q;

  mots_serial_mul u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb), .done_o(mdone), .p_o(mp)
  );

  assign cand  = q_q | (TW'(1) << bit_q);
  assign limit = r_q.sum_neg ? 33'h080000000 : 33'h07FFFFFFF;

  // Multiplier operands chosen by state
  always_comb begin
    ma = '0; mb = '0;
    unique case (state_q)
      S_IDLE: ;
      S_NSS:  begin ma = {55'd0, r_q.n}; mb = {8'd0, r_q.sumsq}; end
      S_S2:   begin ma = {32'd0, r_q.sum_mag}; mb = {32'd0, r_q.sum_mag}; end
      S_CHK:  ;
      S_RHS:  begin ma = s2_q; mb = {23'd0, r_q.n - 9'd1, 32'd0}; end
      S_CSQ:  begin ma = {32'd0, cand}; mb = {32'd0, cand}; end
      S_CD:   begin ma = csq_q; mb = d_q; end
      S_DONE: ;
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; run_q <= 1'b0; done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      run_q  <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start_i) begin state_q <= S_NSS; run_q <= 1'b1; end
        S_NSS:  if (mdone) begin state_q <= S_S2; run_q <= 1'b1; end
        S_S2:   if (mdone) state_q <= S_CHK;
        S_CHK: begin
          if (r_q.n < 9'd2 || nss_q <= s2_q) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_RHS; run_q <= 1'b1;
          end
        end
        S_RHS:  if (mdone) begin state_q <= S_CSQ; run_q <= 1'b1; end
        S_CSQ:  if (mdone) begin state_q <= S_CD; run_q <= 1'b1; end
        S_CD: if (mdone) begin
          if (bit_q == 5'd0) state_q <= S_DONE;
          else begin state_q <= S_CSQ; run_q <= 1'b1; end
        end
        S_DONE: begin state_q <= S_IDLE; done_q <= 1'b1; end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign mstart = run_q;

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      r_q <= req_i; q_q <= '0; bit_q <= 5'd31; st_q <= StOk;
    end
    if (state_q == S_NSS && mdone) nss_q <= mp[63:0];
    if (state_q == S_S2 && mdone) s2_q <= mp[63:0];
    if (state_q == S_CHK) begin
      d_q <= nss_q - s2_q;
      if (r_q.n < 9'd2 || nss_q <= s2_q) st_q <= StDegen;
    end
    if (state_q == S_RHS && mdone) rhs_q <= mp;
    if (state_q == S_CSQ && mdone) csq_q <= mp[63:0];
    if (state_q == S_CD && mdone) begin
      if ({1'b0, cand} <= limit && mp <= rhs_q) q_q <= cand;
      bit_q <= bit_q - 5'd1;
    end
  end

  assign done_o = done_q;
  assign st_o   = st_q;
  assign t_o    = (st_q != StOk) ? '0 : (r_q.sum_neg ? TW'(-q_q) : q_q);

endmodule

// ----- dv/tb.sv -----
// Testbench for the masked one-sample t statistic stream block.
`timescale 1ns / 1ps
module tb;
  import mots_pkg::*;

  localparam int MaxSubjects = 256;
  localparam int TargetItems = 1600;

  typedef struct {
    logic [31:0] t_value;
    logic [1:0]  status;
  } t_result_t;

  // Scoreboard: mirrors the voxel accumulators and predicts each t result
  class tstat_scoreboard;
    bit          use_masks;
    int unsigned subj_cnt;
    int unsigned incl_cnt;
    longint      sum;
    bit [63:0]   sumsq;
    t_result_t   pending_t[$];
    int          err_cnt;

    function void clear_voxel();
      subj_cnt = 0;
      incl_cnt = 0;
      sum      = 0;
      sumsq    = 0;
    endfunction

    function void accumulate_sample(logic signed [23:0] sample,
                                    logic signed [15:0] mask, logic last);
      longint      x;
      bit [63:0]   ax, mag, nss, s2, d, lim, c, q;
      bit [127:0]  rhs, lhs;
      t_result_t   r;
      x = longint'(sample);
      if (subj_cnt >= MaxSubjects) begin
        subj_cnt = MaxSubjects + 1;
      end else begin
        subj_cnt++;
        if (!use_masks || mask > 0) begin
          ax = (x < 0) ? -x : x;
          incl_cnt++;
          sum   += x;
          sumsq += ax * ax;
        end
      end
      if (!last) return;
      mag = (sum < 0) ? -sum : sum;
      nss = 64'(subj_cnt) * sumsq;
      s2  = mag * mag;
      r.t_value = '0;
      if (subj_cnt > MaxSubjects) begin
        r.status = StTooMany;
      end else if (incl_cnt < subj_cnt) begin
        r.status = StMasked;
      end else if (subj_cnt < 2 || nss <= s2) begin
        r.status = StDegen;
      end else begin
        r.status = StOk;
        // bit-by-bit search of the largest q <= lim with q^2*d <= s2*(n-1)*2^32
        d   = nss - s2;
        lim = (sum < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
        rhs = {64'b0, s2} * {64'b0, (64'(subj_cnt) - 64'd1) << 32};
        q   = 0;
        for (int b = 31; b >= 0; b--) begin
          c   = q | (64'd1 << b);
          lhs = {64'b0, c * c} * {64'b0, d};
          if (c <= lim && lhs <= rhs) q = c;
        end
        r.t_value = (sum < 0) ? 32'(-q) : q[31:0];
      end
      pending_t = {pending_t, r};
      clear_voxel();
    endfunction

    function void check_t_result(logic [31:0] t_value, logic [1:0] status);
      t_result_t e;
      if (pending_t.size() == 0) begin
        $error("unexpected result: t_value=%0d status=%0d", $signed(t_value), status);
        err_cnt++;
        return;
      end
      e = pending_t.pop_front();
      if (t_value !== e.t_value) begin
        $error("t_value: expected %0d, actual %0d", $signed(e.t_value), $signed(t_value));
        err_cnt++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        err_cnt++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  tstat_scoreboard sb = new();
  bit no_gaps;
  int items_sent;

  masked_one_sample_t_statistic #(.MAX_SUBJECTS(MaxSubjects)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  initial begin
    #400ms;
    $display("Mismatches found");
    $finish;
  end

  // Drive one sample transaction and record it once accepted
  task automatic send_sample(logic signed [23:0] sample, logic signed [15:0] mask,
                             logic last);
    int gap;
    bit rdy;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {mask, sample};
    s_axis_tlast  <= last;
    // ready is stable between the falling edge and the next rising edge
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    sb.accumulate_sample(sample, mask, last);
    items_sent++;
  endtask

  // Drain pending results, let the block settle, then write use_masks
  task automatic write_use_masks(bit val);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_t.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.use_masks = val;
  endtask

  // Result side: random backpressure, one check per transaction
  initial begin
    int stall;
    bit got;
    logic [31:0] t_s;
    logic [1:0]  st_s;
    @(posedge rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        got  = m_axis_tvalid;
        t_s  = m_axis_tdata;
        st_s = m_axis_tuser;
        @(posedge clk_i);
      end while (!got);
      sb.check_t_result(t_s, st_s);
    end
  end

  // Stimulus
  initial begin
    int len, mode, big_done, vox;
    logic signed [23:0] base, smp;
    logic signed [15:0] msk;
    sb.clear_voxel();
    sb.use_masks = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single sample, equal samples, extremes, saturation both ways
    write_use_masks(1'b0);
    send_sample(24'sh7FFFFF, 16'sd1, 1'b1);
    send_sample(-24'sd8388608, 16'sd0, 1'b0);
    send_sample(-24'sd8388608, 16'sd0, 1'b1);
    send_sample(24'sh7FFFFF, -16'sd32768, 1'b0);
    send_sample(-24'sd8388608, 16'sd32767, 1'b0);
    send_sample(24'sd0, 16'sd0, 1'b1);
    send_sample(24'sh7FFFFF, 16'sd5, 1'b0);
    send_sample(24'sh7FFFFF, 16'sd5, 1'b0);
    send_sample(24'sh7FFFFE, 16'sd5, 1'b1);
    send_sample(-24'sd8388608, 16'sd5, 1'b0);
    send_sample(-24'sd8388608, 16'sd5, 1'b0);
    send_sample(-24'sd8388607, 16'sd5, 1'b1);
    // Directed: masking with zero, most negative and positive mask values
    write_use_masks(1'b1);
    send_sample(24'sd100, 16'sd32767, 1'b0);
    send_sample(24'sd200, 16'sd1, 1'b0);
    send_sample(24'sd300, 16'sd0, 1'b1);
    send_sample(24'sd5, -16'sd32768, 1'b0);
    send_sample(24'sd6, 16'sd5, 1'b1);
    send_sample(24'sd4096, 16'sd7, 1'b0);
    send_sample(-24'sd1234, 16'sd300, 1'b0);
    send_sample(24'sd9000, 16'sd2, 1'b0);
    send_sample(24'sd777, 16'sd1, 1'b1);

    // Random voxels; use_masks flips every few voxels
    big_done = 0;
    vox = 0;
    while (items_sent < TargetItems) begin
      if (vox % 15 == 14) write_use_masks(~sb.use_masks);
      vox++;
      if ($urandom_range(0, 4) == 0) no_gaps = ~no_gaps;
      len = $urandom_range(0, 99);
      if (len < 5) len = 1;
      else if (len < 9 && big_done < 4) begin
        len = (big_done % 2) ? MaxSubjects : MaxSubjects + 1 + big_done;
        big_done++;
      end else len = $urandom_range(2, 14);
      mode = $urandom_range(0, 3);
      base = 24'($urandom);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: smp = 24'($urandom);
          1: smp = 24'(int'(base) + int'($urandom_range(0, 8192)) - 4096);
          2: smp = 24'((base[23] ? -8388600 : 8388600) + int'($urandom_range(0, 3)));
          default: smp = base[0] ? 24'(8388607 - int'($urandom_range(0, 200)))
                                 : 24'(-8388608 + int'($urandom_range(0, 200)));
        endcase
        if ($urandom_range(0, 19) == 0) msk = 16'(-int'($urandom_range(0, 32768)));
        else msk = 16'($urandom_range(1, 32767));
        send_sample(smp, msk, i == len - 1);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending_t.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/mots_pkg.sv
rtl/core/mots_serial_mul.sv
rtl/core/mots_tunit.sv
rtl/core/masked_one_sample_t_statistic.sv
dv/tb.sv
